FILE: rtl/core/double_to_single_narrowing_defines.svh
// Assertion macros used by the checker of this block.
`ifndef DOUBLE_TO_SINGLE_NARROWING_DEFINES_SVH
`define DOUBLE_TO_SINGLE_NARROWING_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define D2S_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d2s assertion failed");

// Next-cycle implication, masked while reset is low.
`define D2S_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("d2s assertion failed");

`endif

FILE: rtl/core/d2s_pkg.sv
package d2s_pkg;

    localparam logic [11:0] EXP_REBIAS   = 12'd896;
    localparam logic [11:0] EXP_MAX      = 12'd255;
    localparam logic [31:0] SGL_POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] SGL_NEG_INF  = 32'hFF80_0000;
    localparam logic [31:0] SGL_HIDDEN   = 32'h0080_0000;

    // Handshake control for one pipeline stage
    typedef struct packed {
        logic load;
        logic valid_in;
    } stage_ctl_t;

    // Decoded operand
    typedef struct packed {
        logic        sign;
        logic        zero;
        logic        denorm;
        logic [10:0] exp11;
        logic [24:0] mant;
        logic [4:0]  add_sh;
        logic [4:0]  rsh;
    } dec_t;

    // Rounded operand
    typedef struct packed {
        logic        sign;
        logic        zero;
        logic        denorm;
        logic [10:0] exp11;
        logic [31:0] sum;
        logic [4:0]  rsh;
    } rnd_t;

endpackage

FILE: rtl/core/double_to_single_narrowing.sv
// Pipeline: three register stages (decode, round, pack); an accepted item goes from the
// decode register to the round register and then to the pack register, which drives the outputs.
// Throughput: one item per cycle while out_stall is low; each stage is a single register
// with its own valid bit, so bubbles close up and an output stall backs up stage by stage.
// Reset: rst_n asynchronous, active low; clears all valid bits and holds in_stall
// high while asserted. Payload registers are not reset.
module double_to_single_narrowing (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] double_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] single_bits,
    output logic        overflow_flag
);

    logic                s1_valid;
    logic                s2_valid;
    d2s_pkg::dec_t       s1_dec;
    d2s_pkg::rnd_t       s2_rnd;
    d2s_pkg::stage_ctl_t s1_ctl;
    d2s_pkg::stage_ctl_t s2_ctl;
    d2s_pkg::stage_ctl_t s3_ctl;
    logic                load_s1;
    logic                load_s2;
    logic                load_s3;

    // A stage loads when it is empty or its contents move on in the same cycle.
    // The output register moves whenever the consumer is not stalling it.
    always_comb
    begin
        load_s3 = !out_valid || !out_stall;
        load_s2 = !s2_valid || load_s3;
        load_s1 = !s1_valid || load_s2;
    end

    // Hold off the producer during reset and whenever the first stage is blocked.
    assign in_stall = !rst_n || !load_s1;

    assign s1_ctl = '{load: load_s1, valid_in: in_valid};
    assign s2_ctl = '{load: load_s2, valid_in: s1_valid};
    assign s3_ctl = '{load: load_s3, valid_in: s2_valid};

    // Stage 1: split the double, flag zero and the denormal range, work out shift counts.
    d2s_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (s1_ctl),
        .double_bits (double_bits),
        .valid       (s1_valid),
        .dec         (s1_dec)
    );

    // Stage 2: add the rounding increment to the working mantissa.
    d2s_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (s2_ctl),
        .dec   (s1_dec),
        .valid (s2_valid),
        .rnd   (s2_rnd)
    );

    // Stage 3: renormalise or denormalise, check for overflow, pack the single.
    // Its registers are the output registers.
    d2s_pack u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (s3_ctl),
        .rnd           (s2_rnd),
        .valid         (out_valid),
        .single_bits   (single_bits),
        .overflow_flag (overflow_flag)
    );

endmodule

FILE: rtl/core/d2s_decode.sv
module d2s_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  d2s_pkg::stage_ctl_t ctl,
    input  logic [63:0]        double_bits,
    output logic               valid,
    output d2s_pkg::dec_t      dec
);

    logic          valid_reg;
    d2s_pkg::dec_t dec_reg;
    d2s_pkg::dec_t dec_next;
    logic [4:0]    n_low;

    always_comb
    begin
        dec_next.sign   = double_bits[63];
        dec_next.zero   = (double_bits[62:0] == 63'd0);
        dec_next.exp11  = double_bits[62:52];
        dec_next.denorm = ({1'b0, double_bits[62:52]} <= d2s_pkg::EXP_REBIAS);
        dec_next.mant   = {1'b1, double_bits[51:28]};
        // low five bits of the denormal shift distance; both counts wrap
        n_low           = d2s_pkg::EXP_REBIAS[4:0] - double_bits[56:52];
        dec_next.add_sh = n_low + 5'd1;
        dec_next.rsh    = n_low + 5'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dec_reg <= dec_next;
        end
    end

    assign valid = valid_reg;
    assign dec   = dec_reg;

endmodule

FILE: rtl/core/d2s_round.sv
module d2s_round (
    input  logic               clk,
    input  logic               rst_n,
    input  d2s_pkg::stage_ctl_t ctl,
    input  d2s_pkg::dec_t      dec,
    output logic               valid,
    output d2s_pkg::rnd_t      rnd
);

    logic          valid_reg;
    d2s_pkg::rnd_t rnd_reg;
    d2s_pkg::rnd_t rnd_next;
    logic [31:0]   addend;

    always_comb
    begin
        // half-up: add one at the round position, no sticky
        addend          = dec.denorm ? (32'd1 << dec.add_sh) : 32'd1;
        rnd_next.sign   = dec.sign;
        rnd_next.zero   = dec.zero;
        rnd_next.denorm = dec.denorm;
        rnd_next.exp11  = dec.exp11;
        rnd_next.rsh    = dec.rsh;
        rnd_next.sum    = {7'd0, dec.mant} + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign valid = valid_reg;
    assign rnd   = rnd_reg;

endmodule

FILE: rtl/core/d2s_pack.sv
module d2s_pack (
    input  logic               clk,
    input  logic               rst_n,
    input  d2s_pkg::stage_ctl_t ctl,
    input  d2s_pkg::rnd_t      rnd,
    output logic               valid,
    output logic [31:0]        single_bits,
    output logic               overflow_flag
);

    logic        valid_reg;
    logic [31:0] single_bits_reg;
    logic [31:0] single_bits_next;
    logic        overflow_flag_reg;
    logic        overflow_flag_next;
    logic [24:0] m1;
    logic        bump;
    logic [22:0] frac;
    logic [11:0] exp_e;
    logic [31:0] den_m;

    always_comb
    begin
        m1    = rnd.sum[25:1];
        bump  = m1[24];
        frac  = bump ? m1[23:1] : m1[22:0];
        exp_e = {1'b0, rnd.exp11} - d2s_pkg::EXP_REBIAS + {11'd0, bump};
        den_m = rnd.sum >> rnd.rsh;

        overflow_flag_next = 1'b0;
        if (rnd.zero)
        begin
            single_bits_next = {rnd.sign, 31'd0};
        end
        else if (rnd.denorm)
        begin
            // hidden bit drops, anything above it passes through
            single_bits_next = {rnd.sign, 31'd0} | (den_m & ~d2s_pkg::SGL_HIDDEN);
        end
        else if (exp_e >= d2s_pkg::EXP_MAX)
        begin
            single_bits_next   = rnd.sign ? d2s_pkg::SGL_NEG_INF : d2s_pkg::SGL_POS_INF;
            overflow_flag_next = 1'b1;
        end
        else
        begin
            single_bits_next = {rnd.sign, exp_e[7:0], frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            single_bits_reg   <= single_bits_next;
            overflow_flag_reg <= overflow_flag_next;
        end
    end

    assign valid         = valid_reg;
    assign single_bits   = single_bits_reg;
    assign overflow_flag = overflow_flag_reg;

endmodule

FILE: rtl/core/d2s_checker.sv
`include "double_to_single_narrowing_defines.svh"

module d2s_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [63:0] double_bits,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] single_bits,
    input logic        overflow_flag
);

    logic        acc_d1_reg;
    logic        acc_d2_reg;
    logic        flow_d1_reg;
    logic        zero_d1_reg;
    logic        zero_d2_reg;
    logic [2:0]  sign_pipe_reg;
    logic        acc_then_flow;
    logic        zero_then_flow;
    logic        ovf_shown;
    logic        out_held;
    logic [32:0] out_word;

    // follow each accepted item along the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_d1_reg    <= 1'b0;
            acc_d2_reg    <= 1'b0;
            flow_d1_reg   <= 1'b0;
            zero_d1_reg   <= 1'b0;
            zero_d2_reg   <= 1'b0;
            sign_pipe_reg <= 3'd0;
        end
        else
        begin
            acc_d1_reg    <= in_valid && !in_stall;
            acc_d2_reg    <= acc_d1_reg;
            flow_d1_reg   <= !out_stall;
            zero_d1_reg   <= (double_bits[62:0] == 63'd0);
            zero_d2_reg   <= zero_d1_reg;
            sign_pipe_reg <= {sign_pipe_reg[1:0], double_bits[63]};
        end
    end

    // an accepted item has reached acc_d2_reg, and flow_d1_reg and out_stall show no output stall since
    assign acc_then_flow  = acc_d2_reg && flow_d1_reg && !out_stall;
    assign zero_then_flow = acc_then_flow && zero_d2_reg;
    assign ovf_shown      = out_valid && overflow_flag;
    assign out_held       = out_valid && out_stall;
    assign out_word       = {overflow_flag, single_bits};

    // overflow always shows as an infinity
    `D2S_ASSERT_IMP(a_ovf_is_inf, clk, rst_n, ovf_shown, single_bits[30:0] == 31'h7F80_0000)

    // held output does not change
    `D2S_ASSERT_NXT(a_stall_hold, clk, rst_n, out_held, out_valid && $stable(out_word))

    // an accepted item reaches the output registers when the output runs free
    `D2S_ASSERT_NXT(a_latency, clk, rst_n, acc_then_flow, out_valid)

    // a zero input of either sign gives a zero with no overflow
    `D2S_ASSERT_NXT(a_zero_in, clk, rst_n, zero_then_flow, out_word == {1'b0, sign_pipe_reg[2], 31'd0})

endmodule

bind double_to_single_narrowing d2s_checker u_d2s_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .double_bits   (double_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .single_bits   (single_bits),
    .overflow_flag (overflow_flag)
);
